>>> rtl/aabb_pkg.sv
package aabb_pkg;

    // default coordinate format
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_FRAC_DEF  = 16;

    // scaled corners carry this many extra integer bits
    localparam int SCALED_EXTRA = 8;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_XY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_Z   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_QUAT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_XY     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Z      = 3'd4;

    // register reset values
    localparam logic [63:0] RST_POSITION_XY   = 64'h0000_0000_0000_0000;
    localparam logic [31:0] RST_POSITION_Z    = 32'h0000_0000;
    localparam logic [63:0] RST_ROTATION_QUAT = 64'h4000_0000_0000_0000;
    localparam logic [63:0] RST_SCALE_XY      = 64'h0001_0000_0001_0000;
    localparam logic [31:0] RST_SCALE_Z       = 32'h0001_0000;

    // quaternion and rotation matrix formats
    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = 14;
    localparam int QPROD_W   = 2 * QUAT_W;
    localparam int ROT_Q_W   = 36;
    localparam int ROT_FRAC  = 16;
    localparam int ROT_SHIFT = 2 * QUAT_FRAC - ROT_FRAC;
    localparam int ROT_W     = 22;

    // cycles from an accepted item to its result strobe
    localparam int PIPE_DEPTH = 9;

    typedef logic signed [ROT_W-1:0] rot_t;

    typedef struct packed {
        logic [63:0] position_xy;
        logic [31:0] position_z;
        logic [63:0] rotation_quat;
        logic [63:0] scale_xy;
        logic [31:0] scale_z;
    } cfg_t;

endpackage

>>> rtl/affine_aabb_transform.sv
// each item passes the scale and row pipelines and the output register before its result strobe
// throughput: one item per cycle, busy stays low, the multiplier pipeline never stalls
// the receiver cannot stall; every result shows on done for exactly one cycle
// reset: in-flight items are dropped, registers return to identity transform
module affine_aabb_transform #(
    parameter int COORD_WIDTH     = aabb_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = aabb_pkg::COORD_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                start,
    output logic                                busy,
    input  logic                                has_mesh,
    input  logic signed [COORD_WIDTH-1:0]       local_min_x,
    input  logic signed [COORD_WIDTH-1:0]       local_min_y,
    input  logic signed [COORD_WIDTH-1:0]       local_min_z,
    input  logic signed [COORD_WIDTH-1:0]       local_max_x,
    input  logic signed [COORD_WIDTH-1:0]       local_max_y,
    input  logic signed [COORD_WIDTH-1:0]       local_max_z,

    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       world_min_x,
    output logic signed [COORD_WIDTH-1:0]       world_min_y,
    output logic signed [COORD_WIDTH-1:0]       world_min_z,
    output logic signed [COORD_WIDTH-1:0]       world_max_x,
    output logic signed [COORD_WIDTH-1:0]       world_max_y,
    output logic signed [COORD_WIDTH-1:0]       world_max_z,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aabb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aabb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW    = COORD_WIDTH + aabb_pkg::SCALED_EXTRA;
    localparam int DEPTH = aabb_pkg::PIPE_DEPTH;

    aabb_pkg::cfg_t cfg;
    aabb_pkg::rot_t rot [3][3];

    logic signed [COORD_WIDTH-1:0] lo [3];
    logic signed [COORD_WIDTH-1:0] hi [3];
    logic signed [COORD_WIDTH-1:0] scl [3];
    logic signed [COORD_WIDTH-1:0] pos [3];
    logic signed [SW-1:0]          umin [3];
    logic signed [SW-1:0]          umax [3];
    logic signed [COORD_WIDTH-1:0] wmin [3];
    logic signed [COORD_WIDTH-1:0] wmax [3];

    logic                   accept;
    logic [DEPTH-1:0]       vld_reg;
    logic [DEPTH-1:0]       vld_next;
    logic [DEPTH-2:0]       mesh_reg;
    logic signed [COORD_WIDTH-1:0] min_reg [3];
    logic signed [COORD_WIDTH-1:0] max_reg [3];

    // item handshake
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    aabb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // register slots to coordinate width
    assign scl[0] = cfg.scale_xy[32 +: COORD_WIDTH];
    assign scl[1] = cfg.scale_xy[0 +: COORD_WIDTH];
    assign scl[2] = cfg.scale_z[0 +: COORD_WIDTH];
    assign pos[0] = cfg.position_xy[32 +: COORD_WIDTH];
    assign pos[1] = cfg.position_xy[0 +: COORD_WIDTH];
    assign pos[2] = cfg.position_z[0 +: COORD_WIDTH];

    assign lo[0] = local_min_x;
    assign lo[1] = local_min_y;
    assign lo[2] = local_min_z;
    assign hi[0] = local_max_x;
    assign hi[1] = local_max_y;
    assign hi[2] = local_max_z;

    // rotation matrix from the quaternion
    aabb_rot u_rot (
        .clk  (clk),
        .quat (cfg.rotation_quat),
        .rot  (rot)
    );

    // scaled box corners
    aabb_scale #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_scale (
        .clk  (clk),
        .lo   (lo),
        .hi   (hi),
        .scl  (scl),
        .umin (umin),
        .umax (umax)
    );

    // one row of the matrix per world axis
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        aabb_row #(
            .COORD_WIDTH     (COORD_WIDTH)
        ) u_row (
            .clk     (clk),
            .rot_row (rot[r]),
            .umin    (umin),
            .umax    (umax),
            .pos     (pos[r]),
            .wmin    (wmin[r]),
            .wmax    (wmax[r])
        );
    end

    // valid bits follow the item down the pipe
    assign vld_next = {vld_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // mesh flag and output stage, empty item gives a zero box
    always_ff @(posedge clk)
    begin
        mesh_reg <= {mesh_reg[DEPTH-3:0], has_mesh};
        for (int a = 0; a < 3; a++)
        begin
            min_reg[a] <= mesh_reg[DEPTH-2] ? wmin[a] : '0;
            max_reg[a] <= mesh_reg[DEPTH-2] ? wmax[a] : '0;
        end
    end

    assign done        = vld_reg[DEPTH-1];
    assign world_min_x = min_reg[0];
    assign world_min_y = min_reg[1];
    assign world_min_z = min_reg[2];
    assign world_max_x = max_reg[0];
    assign world_max_y = max_reg[1];
    assign world_max_z = max_reg[2];

endmodule

>>> rtl/aabb_cfg.sv
module aabb_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aabb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aabb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output aabb_pkg::cfg_t                      cfg
);

    aabb_pkg::cfg_t cfg_reg;
    aabb_pkg::cfg_t cfg_next;

    // writes are always accepted, cfg_ready is tied high
    assign cfg_ready = 1'b1;

    // register write decode, unknown index leaves everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                aabb_pkg::REG_POSITION_XY:   cfg_next.position_xy   = cfg_data;
                aabb_pkg::REG_POSITION_Z:    cfg_next.position_z    = cfg_data[31:0];
                aabb_pkg::REG_ROTATION_QUAT: cfg_next.rotation_quat = cfg_data;
                aabb_pkg::REG_SCALE_XY:      cfg_next.scale_xy      = cfg_data;
                aabb_pkg::REG_SCALE_Z:       cfg_next.scale_z       = cfg_data[31:0];
                default:                     cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_xy   <= aabb_pkg::RST_POSITION_XY;
            cfg_reg.position_z    <= aabb_pkg::RST_POSITION_Z;
            cfg_reg.rotation_quat <= aabb_pkg::RST_ROTATION_QUAT;
            cfg_reg.scale_xy      <= aabb_pkg::RST_SCALE_XY;
            cfg_reg.scale_z       <= aabb_pkg::RST_SCALE_Z;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/aabb_rot.sv
module aabb_rot (
    input  logic            clk,
    input  logic [63:0]     quat,
    output aabb_pkg::rot_t  rot [3][3]
);

    localparam int QW  = aabb_pkg::QUAT_W;
    localparam int QPW = aabb_pkg::QPROD_W;
    localparam int RQW = aabb_pkg::ROT_Q_W;

    localparam logic signed [RQW-1:0] ONE_Q  = RQW'(1) <<< (2 * aabb_pkg::QUAT_FRAC);
    localparam logic signed [RQW-1:0] HALF_Q = RQW'(1) <<< (aabb_pkg::ROT_SHIFT - 1);

    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;

    logic signed [QPW-1:0] xx_reg;
    logic signed [QPW-1:0] yy_reg;
    logic signed [QPW-1:0] zz_reg;
    logic signed [QPW-1:0] xy_reg;
    logic signed [QPW-1:0] xz_reg;
    logic signed [QPW-1:0] yz_reg;
    logic signed [QPW-1:0] wx_reg;
    logic signed [QPW-1:0] wy_reg;
    logic signed [QPW-1:0] wz_reg;

    logic signed [RQW-1:0] ent [3][3];
    aabb_pkg::rot_t        rot_reg [3][3];

    function automatic logic signed [RQW-1:0] ext(input logic signed [QPW-1:0] v);
        return RQW'(v);
    endfunction

    function automatic aabb_pkg::rot_t rnd_rot(input logic signed [RQW-1:0] v);
        logic signed [RQW-1:0] t;
        t = (v + HALF_Q) >>> aabb_pkg::ROT_SHIFT;
        return t[aabb_pkg::ROT_W-1:0];
    endfunction

    assign qw = quat[63:48];
    assign qx = quat[47:32];
    assign qy = quat[31:16];
    assign qz = quat[15:0];

    // quaternion component products
    always_ff @(posedge clk)
    begin
        xx_reg <= qx * qx;
        yy_reg <= qy * qy;
        zz_reg <= qz * qz;
        xy_reg <= qx * qy;
        xz_reg <= qx * qz;
        yz_reg <= qy * qz;
        wx_reg <= qw * qx;
        wy_reg <= qw * qy;
        wz_reg <= qw * qz;
    end

    // matrix entries in Q.28
    always_comb
    begin
        ent[0][0] = ONE_Q - ((ext(yy_reg) + ext(zz_reg)) <<< 1);
        ent[0][1] = (ext(xy_reg) - ext(wz_reg)) <<< 1;
        ent[0][2] = (ext(xz_reg) + ext(wy_reg)) <<< 1;
        ent[1][0] = (ext(xy_reg) + ext(wz_reg)) <<< 1;
        ent[1][1] = ONE_Q - ((ext(xx_reg) + ext(zz_reg)) <<< 1);
        ent[1][2] = (ext(yz_reg) - ext(wx_reg)) <<< 1;
        ent[2][0] = (ext(xz_reg) - ext(wy_reg)) <<< 1;
        ent[2][1] = (ext(yz_reg) + ext(wx_reg)) <<< 1;
        ent[2][2] = ONE_Q - ((ext(xx_reg) + ext(yy_reg)) <<< 1);
    end

    // round to Q.16
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rot_reg[r][c] <= rnd_rot(ent[r][c]);
            end
        end
    end

    assign rot = rot_reg;

endmodule

>>> rtl/aabb_scale.sv
module aabb_scale #(
    parameter int COORD_WIDTH     = aabb_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = aabb_pkg::COORD_FRAC_DEF
) (
    input  logic                                                    clk,
    input  logic signed [COORD_WIDTH-1:0]                           lo [3],
    input  logic signed [COORD_WIDTH-1:0]                           hi [3],
    input  logic signed [COORD_WIDTH-1:0]                           scl [3],
    output logic signed [COORD_WIDTH+aabb_pkg::SCALED_EXTRA-1:0]    umin [3],
    output logic signed [COORD_WIDTH+aabb_pkg::SCALED_EXTRA-1:0]    umax [3]
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int RW = PW + 1;
    localparam int SW = COORD_WIDTH + aabb_pkg::SCALED_EXTRA;

    localparam logic signed [RW-1:0] HALF  = RW'(1) <<< (COORD_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] U_MAX = (RW'(1) <<< (SW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] U_MIN = ~U_MAX;

    logic signed [PW-1:0] plo_reg [3];
    logic signed [PW-1:0] phi_reg [3];
    logic signed [SW-1:0] ulo_reg [3];
    logic signed [SW-1:0] uhi_reg [3];
    logic signed [SW-1:0] umin_reg [3];
    logic signed [SW-1:0] umax_reg [3];

    function automatic logic signed [SW-1:0] rnd_sat(input logic signed [PW-1:0] p);
        logic signed [RW-1:0] t;
        t = (RW'(p) + HALF) >>> COORD_FRAC_BITS;
        return (t > U_MAX) ? U_MAX[SW-1:0] : ((t < U_MIN) ? U_MIN[SW-1:0] : t[SW-1:0]);
    endfunction

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            // scale times both input corners
            plo_reg[a]  <= lo[a] * scl[a];
            phi_reg[a]  <= hi[a] * scl[a];
            // back to the coordinate fraction, clamped to the wider scaled range
            ulo_reg[a]  <= rnd_sat(plo_reg[a]);
            uhi_reg[a]  <= rnd_sat(phi_reg[a]);
            // order the two per axis
            umin_reg[a] <= (ulo_reg[a] < uhi_reg[a]) ? ulo_reg[a] : uhi_reg[a];
            umax_reg[a] <= (ulo_reg[a] < uhi_reg[a]) ? uhi_reg[a] : ulo_reg[a];
        end
    end

    assign umin = umin_reg;
    assign umax = umax_reg;

endmodule

>>> rtl/aabb_row.sv
module aabb_row #(
    parameter int COORD_WIDTH     = aabb_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                    clk,
    input  aabb_pkg::rot_t                                          rot_row [3],
    input  logic signed [COORD_WIDTH+aabb_pkg::SCALED_EXTRA-1:0]    umin [3],
    input  logic signed [COORD_WIDTH+aabb_pkg::SCALED_EXTRA-1:0]    umax [3],
    input  logic signed [COORD_WIDTH-1:0]                           pos,
    output logic signed [COORD_WIDTH-1:0]                           wmin,
    output logic signed [COORD_WIDTH-1:0]                           wmax
);

    localparam int SW  = COORD_WIDTH + aabb_pkg::SCALED_EXTRA;
    localparam int LOW = SW / 2;
    localparam int HIW = SW - LOW;
    localparam int RTW = aabb_pkg::ROT_W;
    localparam int PHW = RTW + HIW;
    localparam int PLW = RTW + LOW + 1;
    localparam int TW  = RTW + SW;
    localparam int AW  = TW + 2;
    localparam int XW  = AW + 1;

    localparam logic signed [XW-1:0] O_HALF = XW'(1) <<< (aabb_pkg::ROT_FRAC - 1);
    localparam logic signed [XW-1:0] O_MAX  = (XW'(1) <<< (COORD_WIDTH - 1)) - XW'(1);
    localparam logic signed [XW-1:0] O_MIN  = ~O_MAX;

    // index 0 builds the lower bound, index 1 the upper bound
    logic signed [SW-1:0]  op [2][3];
    logic signed [PHW-1:0] ph_reg [2][3];
    logic signed [PLW-1:0] pl_reg [2][3];
    logic signed [TW-1:0]  term_reg [2][3];
    logic signed [AW-1:0]  s01_reg [2];
    logic signed [AW-1:0]  s2p_reg [2];
    logic signed [AW-1:0]  acc_reg [2];
    logic signed [COORD_WIDTH-1:0] w_reg [2];

    function automatic logic signed [COORD_WIDTH-1:0] rnd_sat(input logic signed [AW-1:0] v);
        logic signed [XW-1:0] t;
        t = (XW'(v) + O_HALF) >>> aabb_pkg::ROT_FRAC;
        return (t > O_MAX) ? O_MAX[COORD_WIDTH-1:0]
             : ((t < O_MIN) ? O_MIN[COORD_WIDTH-1:0] : t[COORD_WIDTH-1:0]);
    endfunction

    // a negative matrix entry flips which corner gives the extreme
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            op[0][a] = rot_row[a][RTW-1] ? umax[a] : umin[a];
            op[1][a] = rot_row[a][RTW-1] ? umin[a] : umax[a];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int m = 0; m < 2; m++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                // split product, high signed half and low unsigned half
                ph_reg[m][a]   <= rot_row[a] * $signed(op[m][a][SW-1:LOW]);
                pl_reg[m][a]   <= rot_row[a] * $signed({1'b0, op[m][a][LOW-1:0]});
                // recombine
                term_reg[m][a] <= (TW'(ph_reg[m][a]) <<< LOW) + TW'(pl_reg[m][a]);
            end
            // sum the three terms and the translation
            s01_reg[m] <= AW'(term_reg[m][0]) + AW'(term_reg[m][1]);
            s2p_reg[m] <= AW'(term_reg[m][2]) + (AW'(pos) <<< aabb_pkg::ROT_FRAC);
            acc_reg[m] <= s01_reg[m] + s2p_reg[m];
            // round and clamp to coordinate range
            w_reg[m]   <= rnd_sat(acc_reg[m]);
        end
    end

    assign wmin = w_reg[0];
    assign wmax = w_reg[1];

endmodule

>>> tb/sv/aabb_transform_checker.sv
module aabb_transform_checker
    import aabb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      has_mesh,
    input  logic [COORD_WIDTH_DEF-1:0] local_min_x,
    input  logic [COORD_WIDTH_DEF-1:0] local_min_y,
    input  logic [COORD_WIDTH_DEF-1:0] local_min_z,
    input  logic [COORD_WIDTH_DEF-1:0] local_max_x,
    input  logic [COORD_WIDTH_DEF-1:0] local_max_y,
    input  logic [COORD_WIDTH_DEF-1:0] local_max_z,
    input  logic                      done,
    input  logic [COORD_WIDTH_DEF-1:0] world_min_x,
    input  logic [COORD_WIDTH_DEF-1:0] world_min_y,
    input  logic [COORD_WIDTH_DEF-1:0] world_min_z,
    input  logic [COORD_WIDTH_DEF-1:0] world_max_x,
    input  logic [COORD_WIDTH_DEF-1:0] world_max_y,
    input  logic [COORD_WIDTH_DEF-1:0] world_max_z,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output int                        mismatches,
    output int                        outstanding,
    output int                        boxes_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = COORD_WIDTH_DEF;
    localparam int F = COORD_FRAC_DEF;

    // six coordinates: min x,y,z in slots 0..2, max x,y,z in slots 3..5
    typedef logic [5:0][W-1:0] box_t;

    // shadow copy of the register file
    logic [63:0] position_xy;
    logic [31:0] position_z;
    logic [63:0] rotation_quat;
    logic [63:0] scale_xy;
    logic [31:0] scale_z;

    box_t expected_boxes[$];
    box_t observed_box;
    box_t wanted_box;
    int   slot;

    function automatic longint round_half_up(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint coord(logic [W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint quat_part(logic [QUAT_W-1:0] v);
        return longint'($signed(v));
    endfunction

    // world box from the current registers: translate * rotate * scale on all eight corners
    function automatic box_t predict_world_box(logic mesh, box_t corners);
        longint qw, qx, qy, qz, one, acc, w;
        longint rot[3][3];
        longint s[3];
        longint p[3];
        longint u[3];
        longint wmin[3];
        longint wmax[3];
        box_t   box;
        int     k, a, r;
        box = '0;
        if (!mesh)
            return box;

        qw  = quat_part(rotation_quat[63:48]);
        qx  = quat_part(rotation_quat[47:32]);
        qy  = quat_part(rotation_quat[31:16]);
        qz  = quat_part(rotation_quat[15:0]);
        one = longint'(1) <<< (2 * QUAT_FRAC);

        // rotation matrix, exact in Q.28, then rounded to Q.16
        rot[0][0] = one - 2 * (qy * qy + qz * qz);
        rot[0][1] = 2 * (qx * qy - qw * qz);
        rot[0][2] = 2 * (qx * qz + qw * qy);
        rot[1][0] = 2 * (qx * qy + qw * qz);
        rot[1][1] = one - 2 * (qx * qx + qz * qz);
        rot[1][2] = 2 * (qy * qz - qw * qx);
        rot[2][0] = 2 * (qx * qz - qw * qy);
        rot[2][1] = 2 * (qy * qz + qw * qx);
        rot[2][2] = one - 2 * (qx * qx + qy * qy);
        for (r = 0; r < 3; r++)
            for (a = 0; a < 3; a++)
                rot[r][a] = round_half_up(rot[r][a], ROT_SHIFT);

        s[0] = coord(scale_xy[63:32]);
        s[1] = coord(scale_xy[31:0]);
        s[2] = coord(scale_z);
        p[0] = coord(position_xy[63:32]);
        p[1] = coord(position_xy[31:0]);
        p[2] = coord(position_z);

        for (k = 0; k < 8; k++) begin
            // scaled corner, saturated to the wider intermediate range
            for (a = 0; a < 3; a++)
                u[a] = clamp_signed(round_half_up(
                    s[a] * coord(((k >> a) & 1) != 0 ? corners[a + 3] : corners[a]), F),
                    W + SCALED_EXTRA);
            for (r = 0; r < 3; r++) begin
                acc = p[r] <<< ROT_FRAC;
                for (a = 0; a < 3; a++)
                    acc += rot[r][a] * u[a];
                w = clamp_signed(round_half_up(acc, ROT_FRAC), W);
                if (k == 0 || w < wmin[r])
                    wmin[r] = w;
                if (k == 0 || w > wmax[r])
                    wmax[r] = w;
            end
        end

        for (a = 0; a < 3; a++) begin
            box[a]     = wmin[a][W-1:0];
            box[a + 3] = wmax[a][W-1:0];
        end
        return box;
    endfunction

    function automatic string field_name(int i);
        case (i)
            0:       return "world_min_x";
            1:       return "world_min_y";
            2:       return "world_min_z";
            3:       return "world_max_x";
            4:       return "world_max_y";
            default: return "world_max_z";
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // track register writes, predict on accepted items, compare on result strobes
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            position_xy   = RST_POSITION_XY;
            position_z    = RST_POSITION_Z;
            rotation_quat = RST_ROTATION_QUAT;
            scale_xy      = RST_SCALE_XY;
            scale_z       = RST_SCALE_Z;
            expected_boxes.delete();
            mismatches     = 0;
            boxes_compared = 0;
            outstanding   <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_POSITION_XY:   position_xy   = cfg_data;
                    REG_POSITION_Z:    position_z    = cfg_data[31:0];
                    REG_ROTATION_QUAT: rotation_quat = cfg_data;
                    REG_SCALE_XY:      scale_xy      = cfg_data;
                    REG_SCALE_Z:       scale_z       = cfg_data[31:0];
                    default: ;
                endcase
            end

            if (start && !busy)
                expected_boxes.push_back(predict_world_box(has_mesh,
                    {local_max_z, local_max_y, local_max_x,
                     local_min_z, local_min_y, local_min_x}));

            if (done) begin
                observed_box = {world_max_z, world_max_y, world_max_x,
                                world_min_z, world_min_y, world_min_x};
                if (expected_boxes.size() == 0) begin
                    report_mismatch($sformatf("result %h with no item outstanding",
                                              observed_box));
                end
                else begin
                    wanted_box = expected_boxes.pop_front();
                    boxes_compared++;
                    for (slot = 0; slot < 6; slot++)
                        if (observed_box[slot] !== wanted_box[slot])
                            report_mismatch($sformatf("result %0d %s: expected %h, got %h",
                                boxes_compared, field_name(slot),
                                wanted_box[slot], observed_box[slot]));
                end
            end

            outstanding <= expected_boxes.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aabb_pkg::*;

    localparam int W = COORD_WIDTH_DEF;
    localparam int ITEMS_PER_SETTING = 50;
    localparam int SETTING_COUNT     = 35;

    localparam logic [W-1:0] MAX_COORD = 32'h7fff_ffff;
    localparam logic [W-1:0] MIN_COORD = 32'h8000_0000;
    localparam logic [W-1:0] ONE_COORD = 32'h0001_0000;

    typedef logic [5:0][W-1:0] box_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   has_mesh;
    logic [W-1:0]           local_min_x, local_min_y, local_min_z;
    logic [W-1:0]           local_max_x, local_max_y, local_max_z;
    logic                   done;
    logic [W-1:0]           world_min_x, world_min_y, world_min_z;
    logic [W-1:0]           world_max_x, world_max_y, world_max_z;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int boxes_compared;
    int items_sent;
    int settings_applied;

    affine_aabb_transform u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .has_mesh    (has_mesh),
        .local_min_x (local_min_x),
        .local_min_y (local_min_y),
        .local_min_z (local_min_z),
        .local_max_x (local_max_x),
        .local_max_y (local_max_y),
        .local_max_z (local_max_z),
        .done        (done),
        .world_min_x (world_min_x),
        .world_min_y (world_min_y),
        .world_min_z (world_min_z),
        .world_max_x (world_max_x),
        .world_max_y (world_max_y),
        .world_max_z (world_max_z),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    aabb_transform_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .has_mesh       (has_mesh),
        .local_min_x    (local_min_x),
        .local_min_y    (local_min_y),
        .local_min_z    (local_min_z),
        .local_max_x    (local_max_x),
        .local_max_y    (local_max_y),
        .local_max_z    (local_max_z),
        .done           (done),
        .world_min_x    (world_min_x),
        .world_min_y    (world_min_y),
        .world_min_z    (world_min_z),
        .world_max_x    (world_max_x),
        .world_max_y    (world_max_y),
        .world_max_z    (world_max_z),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .boxes_compared (boxes_compared)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("affine_aabb_transform test failed");
        $finish;
    end

    // coordinate mix: extremes, moderate values and raw bit patterns
    function automatic logic [W-1:0] pick_coord();
        case ($urandom_range(15))
            0:                 return MAX_COORD;
            1:                 return MIN_COORD;
            2:                 return '0;
            3:                 return ONE_COORD;
            4:                 return -ONE_COORD;
            5, 6, 7, 8, 9, 10: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
            default:           return $urandom;
        endcase
    endfunction

    function automatic logic [QUAT_W-1:0] pick_quat_part();
        case ($urandom_range(9))
            0:       return 16'h4000;
            1:       return 16'hc000;
            2:       return '0;
            3:       return 16'h2d41;
            4:       return 16'h7fff;
            5:       return 16'h8000;
            default: return QUAT_W'($urandom_range(16'hffff));
        endcase
    endfunction

    function automatic box_t corners(input logic [W-1:0] x0, y0, z0, x1, y1, z1);
        return {z1, y1, x1, z0, y0, x0};
    endfunction

    // mostly ordered boxes with a modest extent, some with unrelated corners
    function automatic box_t random_box();
        box_t b;
        int   a;
        for (a = 0; a < 3; a++) begin
            b[a] = pick_coord();
            if ($urandom_range(9) < 7)
                b[a + 3] = b[a] + $urandom_range(32'h0040_0000);
            else
                b[a + 3] = pick_coord();
        end
        return b;
    endfunction

    task automatic send_box(input logic mesh, input box_t b);
        has_mesh    <= mesh;
        local_min_x <= b[0];
        local_min_y <= b[1];
        local_min_z <= b[2];
        local_max_x <= b[3];
        local_max_y <= b[4];
        local_max_z <= b[5];
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_off(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // all five registers; unused upper bits of the 32-bit ones carry junk
    task automatic apply_setting(input logic [63:0] pos_xy, input logic [31:0] pos_z,
                                 input logic [63:0] quat, input logic [63:0] scl_xy,
                                 input logic [31:0] scl_z, input bit junk_write);
        write_reg(REG_POSITION_XY, pos_xy);
        write_reg(REG_POSITION_Z, {$urandom, pos_z});
        write_reg(REG_ROTATION_QUAT, quat);
        write_reg(REG_SCALE_XY, scl_xy);
        write_reg(REG_SCALE_Z, {$urandom, scl_z});
        // an index past the register file must leave everything unchanged
        if (junk_write)
            write_reg(CFG_INDEX_W'(REG_SCALE_Z + $urandom_range(1, 3)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic random_setting();
        apply_setting({pick_coord(), pick_coord()}, pick_coord(),
                      {pick_quat_part(), pick_quat_part(), pick_quat_part(), pick_quat_part()},
                      {pick_coord(), pick_coord()}, pick_coord(), $urandom_range(3) == 0);
    endtask

    // stimulus
    initial
    begin
        int blk;
        int n;
        int idle_pct;
        rst_n            = 1'b0;
        start            = 1'b0;
        has_mesh         = 1'b0;
        local_min_x      = '0;
        local_min_y      = '0;
        local_min_z      = '0;
        local_max_x      = '0;
        local_max_y      = '0;
        local_max_z      = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        items_sent       = 0;
        settings_applied = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity transform out of reset
        send_box(1'b0, corners(MAX_COORD, MIN_COORD, 32'h1234_5678, '1, ONE_COORD, MIN_COORD));
        send_box(1'b1, '0);
        send_box(1'b1, corners(32'hfffe_0000, 32'hffff_8000, '0,
                               32'h0002_0000, 32'h0000_8000, 32'h0003_0000));
        // min above max on every axis
        send_box(1'b1, corners(32'h0002_0000, 32'h0000_8000, 32'h0003_0000,
                               32'hfffe_0000, 32'hffff_8000, '0));
        send_box(1'b1, corners(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
        send_box(1'b1, corners(MAX_COORD, MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MIN_COORD));
        send_box(1'b1, corners('1, '1, '1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_box(1'b0, '1);
        wait_for_results();

        // extreme translation and scale, quarter turn about z
        apply_setting({MAX_COORD, MIN_COORD}, MAX_COORD, {16'h2d41, 16'h0000, 16'h0000, 16'h2d41},
                      {MAX_COORD, MIN_COORD}, 32'h0002_0000, 1'b1);
        send_box(1'b1, corners('0, '0, '0, ONE_COORD, ONE_COORD, ONE_COORD));
        send_box(1'b1, corners(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
        send_box(1'b1, corners(MAX_COORD, '0, MIN_COORD, '0, MIN_COORD, MAX_COORD));
        send_box(1'b1, corners(-ONE_COORD, -ONE_COORD, -ONE_COORD, '0, '0, '0));
        send_box(1'b1, corners(32'h0000_8000, 32'hffff_8000, '1, 32'h0000_8000, '0, 32'h0000_0001));
        send_box(1'b0, corners(MAX_COORD, MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MIN_COORD));
        wait_for_results();

        // quaternion far from unit length, unit scale, no translation
        apply_setting('0, '0, {4{16'h8000}}, {ONE_COORD, ONE_COORD}, ONE_COORD, 1'b0);
        send_box(1'b1, corners('0, '0, '0, ONE_COORD, ONE_COORD, ONE_COORD));
        send_box(1'b1, corners(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
        send_box(1'b1, corners(32'h0010_0000, 32'hfff0_0000, 32'h0000_4000,
                               32'hffff_0000, 32'h0001_8000, 32'h0020_0000));
        send_box(1'b1, corners(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, '1, '1, '1));
        wait_for_results();

        // zero scale collapses every corner onto the translation
        apply_setting({MIN_COORD, MAX_COORD}, MIN_COORD, {4{16'h7fff}}, '0, '0, 1'b1);
        send_box(1'b1, corners(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
        send_box(1'b1, corners(ONE_COORD, ONE_COORD, ONE_COORD, '0, '0, '0));
        send_box(1'b1, random_box());

        // random boxes in blocks, each under a fresh register setting
        for (blk = 0; blk < SETTING_COUNT; blk++) begin
            idle_pct = (blk < 12) ? 28 : ((blk < 24) ? 55 : 0);
            wait_for_results();
            random_setting();
            for (n = 0; n < ITEMS_PER_SETTING; n++) begin
                hold_off(idle_pct);
                send_box($urandom_range(9) != 0, random_box());
            end
        end

        wait_for_results();
        repeat (PIPE_DEPTH + 4)
            @(posedge clk);

        $display("covered %0d boxes under %0d register settings, %0d results compared",
                 items_sent, settings_applied, boxes_compared);
        $display("sender gaps at 28%%, 55%% and none; empty, swapped and saturating boxes included");
        if (mismatches == 0 && outstanding == 0)
            $display("affine_aabb_transform test passed");
        else
            $display("affine_aabb_transform test failed");
        $finish;
    end

endmodule
